/* sv/evfrt_pkg.sv */
// Shared definitions for the repeat-threshold event filter.
// Holds register indexes, default sizes and the history control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package evfrt_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_GROUPS_DEF    = 2;
  localparam int HISTORY_DEPTH_DEF = 16;

  // Patterns are fixed by the width of the hit vector
  localparam int NUM_PATTERNS = 8;

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_NEGATE_MASK       = 3'd0;
  localparam logic [2:0] REG_PATTERN_GROUP_MAP = 3'd1;
  localparam logic [2:0] REG_GROUP_COUNTS      = 3'd2;
  localparam logic [2:0] REG_GROUP_WINDOWS     = 3'd3;
  localparam logic [2:0] REG_NOHIT_MATCH       = 3'd4;
  localparam logic [2:0] REG_MAX_PROCESSED     = 3'd5;
  localparam logic [2:0] REG_MAX_EMITTED       = 3'd6;
  localparam logic [2:0] REG_MAX_LINES         = 3'd7;

  // Commands from the sequencer to the history store
  typedef struct packed {
    logic push;   // write a new timestamp at the head of the group
    logic clear;  // empty the whole group
    logic rd;     // read one slot of the group
  } hist_ctl_t;

endpackage

`default_nettype wire

/* sv/evfrt_hist.sv */
// Timestamp history store: one circular buffer per group in a single memory.
// Valid bits per entry give the all-empty reset and the clear of a whole group.
// Depends on evfrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evfrt_hist
  import evfrt_pkg::*;
#(
  parameter int NUM_GROUPS    = NUM_GROUPS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  localparam int GW           = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1,
  localparam int SW           = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hist_ctl_t       ctl,
  input  wire logic [GW-1:0]   grp,
  input  wire logic [SW-1:0]   slot,   // slot 0 is the newest entry
  input  wire logic [31:0]     wdata,
  output logic      [31:0]     rdata,
  output logic                 rvalid  // entry was written since the last clear
);

  localparam int ENTRIES = NUM_GROUPS * HISTORY_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [31:0]                                 mem [ENTRIES];
  logic [SW-1:0]                               head [NUM_GROUPS];
  logic [NUM_GROUPS-1:0][HISTORY_DEPTH-1:0]    hvalid;

  logic [SW-1:0] head_cur;
  logic [SW-1:0] head_dec;
  logic [SW:0]   phys_sum;
  logic [SW-1:0] rphys;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  always_comb begin
    head_cur = head[grp];
    head_dec = (head_cur == '0) ? SW'(HISTORY_DEPTH - 1) : head_cur - SW'(1);
    // head + slot modulo depth, both operands already below depth
    phys_sum = {1'b0, head_cur} + {1'b0, slot};
    if (phys_sum >= (SW + 1)'(HISTORY_DEPTH)) begin
      phys_sum = phys_sum - (SW + 1)'(HISTORY_DEPTH);
    end
    rphys = phys_sum[SW-1:0];
    waddr = AW'(int'(grp) * HISTORY_DEPTH + int'(head_dec));
    raddr = AW'(int'(grp) * HISTORY_DEPTH + int'(rphys));
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata  <= mem[raddr];
      rvalid <= hvalid[grp][rphys];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        head[g] <= '0;
      end
    end else begin
      if (ctl.push) begin
        head[grp] <= head_dec;
      end
      // clear wins over the bit set by a push in the same cycle
      if (ctl.clear) begin
        hvalid[grp] <= '0;
      end else if (ctl.push) begin
        hvalid[grp][head_dec] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/event_filter_repeat_threshold.sv */
// Repeat-threshold event filter for a stream of log lines (top level).
// Depends on evfrt_pkg and evfrt_hist.
//
// Each request on the s_ side is one log line. A line that starts a new entry
// is classified by the lowest-index pattern hit: a negated pattern gives no
// match, a grouped pattern pushes the timestamp into that group's history and
// matches only when the threshold count of recent stamps (newest first, each
// no older than the group window) is reached, after which the history is
// emptied; no hit gives the default. Continuation lines inherit their entry's
// state. Lines of matching entries are emitted under the per-entry line limit
// and the total-entry limit; reaching the processing limit sets a sticky stop
// after which every line returns halted=1. One result comes back per line.
// Sequence: a line is accepted, decoded, updated and its result registered
// when no history walk is needed, and a halted line skips the update; a
// grouped hit with threshold n >= 2 adds a history walk before the update,
// since the history memory has one read port and the walk checks one slot
// per cycle, stopping at the first slot that fails. s_tready is low
// while a line is in work. A finished result sits in the output register and
// the next line is accepted while it waits; a new result waits for m_tready.
// Reset empties all histories at once through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module event_filter_repeat_threshold
  import evfrt_pkg::*;
#(
  parameter int NUM_GROUPS    = NUM_GROUPS_DEF,     // 1 to 4
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF   // 1 to 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // line input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [7:0] hit_vector, [39:8] timestamp
  input  wire logic        s_tuser,   // [0] continuation
  // result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] line_index
  output logic      [4:0]  m_tuser,   // [0] emit, [1] in_match, [2] suppressed,
                                      // [3] halted, [4] any_matched
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);   // holds a threshold up to depth

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_WALK   = 5'b00100,
    S_UPDATE = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0]  negate_mask;
  logic [15:0] group_map;
  logic [9:0]  group_counts;
  logic [63:0] group_windows;
  logic        nohit_match;
  logic [31:0] max_processed;
  logic [31:0] max_emitted;
  logic [31:0] max_lines;

  // filter state
  logic        entry_matching;
  logic [31:0] entry_total;
  logic [31:0] lines_in_entry;
  logic [31:0] line_counter;
  logic        seen_match;
  logic        stopped;

  // line in work
  logic        cont_q;
  logic [7:0]  hits_q;
  logic [31:0] now_q;
  logic        halt_q;
  logic        m_q;
  logic        supp_q;
  logic [GW-1:0]    grp_q;
  logic [CNT_W-1:0] thr_q;
  logic [31:0]      win_q;
  logic [CNT_W-1:0] slot_k;   // next slot to read
  logic             pend;     // read data for slot_k-1 arrives this cycle

  // output register
  logic [31:0] out_index;
  logic [4:0]  out_flags;

  // decode
  logic             hit_any;
  logic             hit_neg;
  logic [1:0]       hit_code;
  logic             grouped;
  logic             plain_m;
  logic [GW-1:0]    grp_sel;
  logic [4:0]       cnt_field;
  logic [4:0]       cnt_eff;
  logic [CNT_W-1:0] thr_sel;
  logic [31:0]      win_sel;
  logic             stop_now;

  // history walk
  hist_ctl_t   hctl;
  logic [31:0] hist_rdata;
  logic        hist_rvalid;
  logic        rd_ok;
  logic        walk_fail;
  logic        walk_pass;
  logic        act;
  logic        emit;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_index;
  assign m_tuser   = out_flags;

  // lowest-index hit wins
  always_comb begin
    hit_any  = 1'b0;
    hit_neg  = 1'b0;
    hit_code = 2'd0;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      if (hits_q[i]) begin
        hit_any  = 1'b1;
        hit_neg  = negate_mask[i];
        hit_code = group_map[2*i +: 2];
      end
    end
    grouped = hit_any && !hit_neg && (hit_code != 2'd0) &&
              (int'(hit_code) - 1 < NUM_GROUPS);
    plain_m = hit_any ? !hit_neg : nohit_match;
    grp_sel = GW'(int'(hit_code) - 1);

    // groups past the packed fields read threshold 1 and window 0
    if (int'(grp_sel) == 0) begin
      cnt_field = group_counts[4:0];
      win_sel   = group_windows[31:0];
    end else if (int'(grp_sel) == 1) begin
      cnt_field = group_counts[9:5];
      win_sel   = group_windows[63:32];
    end else begin
      cnt_field = 5'd0;
      win_sel   = 32'd0;
    end
    cnt_eff = (cnt_field == 5'd0) ? 5'd1 : cnt_field;
    thr_sel = (int'(cnt_eff) > HISTORY_DEPTH) ? CNT_W'(HISTORY_DEPTH) : CNT_W'(cnt_eff);

    stop_now = stopped || (!cont_q && (entry_total >= max_processed));
  end

  // slot check on registered read data; empty or zero stamp ends the walk
  always_comb begin
    rd_ok     = hist_rvalid && (hist_rdata != 32'd0) && ((now_q - hist_rdata) <= win_q);
    walk_fail = pend && !rd_ok;
    walk_pass = pend && rd_ok && (slot_k == thr_q);

    hctl.push  = (state == S_DECODE) && !stop_now && !cont_q && grouped;
    hctl.clear = (hctl.push && (now_q != 32'd0) && (thr_sel == CNT_W'(1))) ||
                 ((state == S_WALK) && walk_pass);
    hctl.rd    = (state == S_WALK) && !walk_fail && !walk_pass && (slot_k < thr_q);

    act  = !halt_q && entry_matching;
    emit = act && (lines_in_entry < max_lines) && (entry_total <= max_emitted);
  end

  evfrt_hist #(
    .NUM_GROUPS    (NUM_GROUPS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .ctl    (hctl),
    .grp    ((state == S_DECODE) ? grp_sel : grp_q),
    .slot   (slot_k[SW-1:0]),
    .wdata  (now_q),
    .rdata  (hist_rdata),
    .rvalid (hist_rvalid)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      negate_mask   <= 8'd0;
      group_map     <= 16'd0;
      group_counts  <= 10'd33;
      group_windows <= 64'd0;
      nohit_match   <= 1'b1;
      max_processed <= U32_MAX;
      max_emitted   <= U32_MAX;
      max_lines     <= U32_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NEGATE_MASK:       negate_mask   <= cfg_data[7:0];
        REG_PATTERN_GROUP_MAP: group_map     <= cfg_data[15:0];
        REG_GROUP_COUNTS:      group_counts  <= cfg_data[9:0];
        REG_GROUP_WINDOWS:     group_windows <= cfg_data;
        REG_NOHIT_MATCH:       nohit_match   <= cfg_data[0];
        REG_MAX_PROCESSED:     max_processed <= cfg_data[31:0];
        REG_MAX_EMITTED:       max_emitted   <= cfg_data[31:0];
        REG_MAX_LINES:         max_lines     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // line payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cont_q <= s_tuser;
      hits_q <= s_tdata[7:0];
      now_q  <= s_tdata[39:8];
    end
    if (state == S_DECODE) begin
      grp_q <= grp_sel;
      thr_q <= thr_sel;
      win_q <= win_sel;
    end
    if ((state == S_RESULT) && (!m_tvalid || m_tready)) begin
      out_index <= halt_q ? 32'd0 : line_counter;
      out_flags <= {seen_match || act, halt_q, supp_q, entry_matching, emit};
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entry_matching <= 1'b0;
      entry_total    <= 32'd0;
      lines_in_entry <= 32'd0;
      line_counter   <= 32'd0;
      seen_match     <= 1'b0;
      stopped        <= 1'b0;
      halt_q         <= 1'b0;
      m_q            <= 1'b0;
      supp_q         <= 1'b0;
      slot_k         <= '0;
      pend           <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // a new result loads when the register is free or being drained
      if ((state == S_RESULT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          halt_q <= stop_now;
          // zero stamp on a grouped new entry reads as empty: suppressed
          supp_q <= !stop_now && !cont_q && grouped && (now_q == 32'd0);
          if (stop_now) begin
            stopped <= 1'b1;
            state   <= S_RESULT;
          end else begin
            line_counter <= line_counter + 32'd1;
            if (!cont_q && grouped) begin
              if (now_q == 32'd0) begin
                m_q   <= 1'b0;
                state <= S_UPDATE;
              end else if (thr_sel == CNT_W'(1)) begin
                m_q   <= 1'b1;
                state <= S_UPDATE;
              end else begin
                slot_k <= CNT_W'(1);
                pend   <= 1'b0;
                state  <= S_WALK;
              end
            end else begin
              m_q   <= plain_m;
              state <= S_UPDATE;
            end
          end
        end
        S_WALK: begin
          if (walk_fail) begin
            m_q    <= 1'b0;
            supp_q <= 1'b1;
            pend   <= 1'b0;
            state  <= S_UPDATE;
          end else if (walk_pass) begin
            m_q   <= 1'b1;
            pend  <= 1'b0;
            state <= S_UPDATE;
          end else if (hctl.rd) begin
            slot_k <= slot_k + CNT_W'(1);
            pend   <= 1'b1;
          end
        end
        S_UPDATE: begin
          if (!cont_q) begin
            entry_matching <= m_q;
            lines_in_entry <= 32'd0;
            if (m_q && (entry_total != U32_MAX)) begin
              entry_total <= entry_total + 32'd1;
            end
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            if (act) begin
              seen_match <= 1'b1;
              if (lines_in_entry != U32_MAX) begin
                lines_in_entry <= lines_in_entry + 32'd1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stop is sticky until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag dropped");

  // a halted result carries no line number and is never emitted
  a_halt_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3]) |-> ((m_tdata == 32'd0) && !m_tuser[0] && !m_tuser[2]))
    else $error("halted result carries data");

  // an emitted line belongs to a matching entry
  a_emit_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[1] && m_tuser[4]))
    else $error("emit without match");

  // walk never reads past the threshold
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ((slot_k <= thr_q) && (slot_k != '0)))
    else $error("history walk out of range");

  // history is only touched for a grouped new entry or during the walk
  a_hist_use: assert property (@(posedge clk) disable iff (rst)
    (hctl.push || hctl.rd) |-> ((state == S_DECODE) || (state == S_WALK)))
    else $error("history access outside decode or walk");

endmodule

`default_nettype wire
